FILE: hdl/affine_matrix_decompose_trs_top_defines.svh
// Assertion macros used by the checker file.
`ifndef AFFINE_MATRIX_DECOMPOSE_TRS_TOP_DEFINES_SVH
`define AFFINE_MATRIX_DECOMPOSE_TRS_TOP_DEFINES_SVH
// property that must hold at every clock edge outside reset
`define AMD_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// same-cycle implication outside reset
`define AMD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

FILE: hdl/amdtrs_pkg.sv
// Shared constants and types for the affine matrix decomposition pipeline.
package amdtrs_pkg;
   localparam int SQ_STEPS = 32;                 // root bits of the 64-bit square root
   localparam int SQ_LAT   = SQ_STEPS;
   localparam int QB       = 31;                 // quotient bits of the divider
   localparam int DIV_LAT  = QB + 1;             // setup stage plus one bit per stage
   localparam int LA_LAT   = 2 + SQ_LAT;         // squares, sums, root
   localparam int RSP_LAT  = LA_LAT + DIV_LAT + 3 + SQ_LAT + DIV_LAT + 1;

   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   typedef struct packed {
      logic [2:0][31:0] move;
      logic [8:0][31:0] elem;   // index row*3+col
   } side_a_type;

   typedef struct packed {
      logic [2:0][31:0] move;
      logic [2:0][31:0] len;
      logic             bad;
   } side_b_type;

   typedef struct packed {
      logic [2:0][31:0] move;
      logic [2:0][31:0] len;
      logic             bad;
      logic             trace_pos;
      axis_type         axis;
      logic [2:0]       dneg;
      logic [2:0][31:0] dmag;
   } side_c_type;

   typedef struct packed {
      logic [2:0][31:0] move;
      logic [2:0][31:0] len;
      logic             bad;
      logic             trace_pos;
      axis_type         axis;
      logic [31:0]      root;
   } side_d_type;
endpackage

FILE: hdl/affine_matrix_decompose_trs_top.sv
// Top level: affine matrix to translation, rotation quaternion and scale.
//
// A request is taken at each rising edge with start high and busy low; busy
// is always low, so a new matrix may be sent every cycle. Inputs are the
// twelve Q16.16 elements of the top three matrix rows.
// Each request gives one response, marked by a single-cycle rsp_valid
// strobe. Throughput is one matrix per cycle.
// The pipeline holds two 32-stage square roots (column lengths, quaternion
// root) and two 32-stage dividers (column normalize, off-diagonal terms),
// plus squaring, sum and three branch-select stages and the output register.
// The receiver cannot stall; responses leave in request order.
// Synchronous reset clears all valid bits; requests in flight are dropped.
// rsp_bad_matrix flags a zero column or, on the non-positive-trace branch, a
// non-positive root argument, and the quaternion then reads as identity.
module affine_matrix_decompose_trs_top
   import amdtrs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_row0_col0,
   input  logic signed [31:0] req_row0_col1,
   input  logic signed [31:0] req_row0_col2,
   input  logic signed [31:0] req_row0_col3,
   input  logic signed [31:0] req_row1_col0,
   input  logic signed [31:0] req_row1_col1,
   input  logic signed [31:0] req_row1_col2,
   input  logic signed [31:0] req_row1_col3,
   input  logic signed [31:0] req_row2_col0,
   input  logic signed [31:0] req_row2_col1,
   input  logic signed [31:0] req_row2_col2,
   input  logic signed [31:0] req_row2_col3,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_move_x,
   output logic signed [31:0] rsp_move_y,
   output logic signed [31:0] rsp_move_z,
   output logic signed [31:0] rsp_quat_w,
   output logic signed [31:0] rsp_quat_x,
   output logic signed [31:0] rsp_quat_y,
   output logic signed [31:0] rsp_quat_z,
   output logic        [31:0] rsp_size_x,
   output logic        [31:0] rsp_size_y,
   output logic        [31:0] rsp_size_z,
   output logic               rsp_bad_matrix
);
   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // ---------------- column lengths ----------------
   side_a_type         side_a_in;
   side_a_type         side_a_ff [LA_LAT];
   logic [LA_LAT-1:0]  va_ff;
   logic [63:0]        sq_in  [3][3];
   logic [63:0]        sq_ff  [3][3];
   logic [63:0]        sum_in [3];
   logic [63:0]        sum_ff [3];
   logic [31:0]        len    [3];

   always_comb begin
      side_a_in.move[0] = req_row0_col3;
      side_a_in.move[1] = req_row1_col3;
      side_a_in.move[2] = req_row2_col3;
      side_a_in.elem[0] = req_row0_col0;
      side_a_in.elem[1] = req_row0_col1;
      side_a_in.elem[2] = req_row0_col2;
      side_a_in.elem[3] = req_row1_col0;
      side_a_in.elem[4] = req_row1_col1;
      side_a_in.elem[5] = req_row1_col2;
      side_a_in.elem[6] = req_row2_col0;
      side_a_in.elem[7] = req_row2_col1;
      side_a_in.elem[8] = req_row2_col2;
   end

   always_comb begin
      logic signed [31:0] e;
      logic signed [63:0] p;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            e = $signed(side_a_in.elem[r*3+c]);
            p = e * e;
            sq_in[c][r] = p;
         end
         sum_in[c] = sq_ff[c][0] + sq_ff[c][1] + sq_ff[c][2];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            sq_ff[c][r] <= sq_in[c][r];
         end
         sum_ff[c] <= sum_in[c];
      end
      side_a_ff[0] <= side_a_in;
      for (int n = 1; n < LA_LAT; n++) begin
         side_a_ff[n] <= side_a_ff[n-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
      end else begin
         va_ff <= {va_ff[LA_LAT-2:0], accept};
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_len
      amdtrs_sqrt u_sqrt (
         .clock    (clock),
         .radicand (sum_ff[c]),
         .root     (len[c])
      );
   end

   // ---------------- column normalize ----------------
   side_a_type          sa_end;
   side_b_type          side_b_in;
   side_b_type          side_b_ff [DIV_LAT];
   logic [DIV_LAT-1:0]  vb_ff;
   logic                nneg  [9];
   logic [61:0]         nmag  [9];
   logic [QB-1:0]       nq    [9];
   logic                nqneg [9];
   logic                novf  [9];

   assign sa_end = side_a_ff[LA_LAT-1];

   always_comb begin
      logic [31:0] ab;
      for (int n = 0; n < 9; n++) begin
         nneg[n] = sa_end.elem[n][31];
         ab      = nneg[n] ? (32'd0 - sa_end.elem[n]) : sa_end.elem[n];
         nmag[n] = {ab, 30'd0};
      end
      side_b_in.move = sa_end.move;
      for (int c = 0; c < 3; c++) begin
         side_b_in.len[c] = len[c];
      end
      side_b_in.bad = (len[0] == '0) | (len[1] == '0) | (len[2] == '0);
   end

   for (genvar n = 0; n < 9; n++) begin : g_norm
      amdtrs_div u_div (
         .clock   (clock),
         .neg_in  (nneg[n]),
         .mag     (nmag[n]),
         .den     (len[n % 3]),
         .quot    (nq[n]),
         .neg_out (nqneg[n]),
         .ovf     (novf[n])
      );
   end

   always_ff @(posedge clock) begin
      side_b_ff[0] <= side_b_in;
      for (int n = 1; n < DIV_LAT; n++) begin
         side_b_ff[n] <= side_b_ff[n-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= '0;
      end else begin
         vb_ff <= {vb_ff[DIV_LAT-2:0], va_ff[LA_LAT-1]};
      end
   end

   // ---------------- branch select ----------------
   // overflow can only show on a zero column, which is flagged bad anyway
   logic                r_unused;
   logic signed [31:0]  r1_in [9];
   logic signed [31:0]  r1_ff [9];
   logic signed [31:0]  r2_ff [9];
   side_b_type          sb1_ff, sb2_ff, sb3_ff;
   logic                v1_ff, v2_ff, v3_ff;
   logic signed [33:0]  trace_in, trace_ff;
   axis_type            axis_in, axis_ff, axis3_ff;
   logic                tpos_ff, tpos3_ff;
   logic signed [33:0]  arg_in,  arg_ff;
   logic [2:0]          dneg_in, dneg_ff;
   logic [2:0][31:0]    dmag_in, dmag_ff;
   logic                bad3_ff;

   always_comb begin
      r_unused = 1'b0;
      for (int n = 0; n < 9; n++) begin
         r1_in[n] = nqneg[n] ? (32'sd0 - $signed({1'b0, nq[n]})) : $signed({1'b0, nq[n]});
         r_unused = r_unused | novf[n];
      end
   end

   always_comb begin
      logic signed [33:0] a0, a1, a2;
      a0 = r1_ff[0];
      a1 = r1_ff[4];
      a2 = r1_ff[8];
      trace_in = a0 + a1 + a2;
      if ((r1_ff[4] > r1_ff[0]) && !(r1_ff[8] > r1_ff[4])) begin
         axis_in = AXIS_Y;
      end else if (r1_ff[4] > r1_ff[0]) begin
         axis_in = AXIS_Z;
      end else if (r1_ff[8] > r1_ff[0]) begin
         axis_in = AXIS_Z;
      end else begin
         axis_in = AXIS_X;
      end
   end

   always_comb begin
      logic signed [33:0] rx [9];
      logic signed [33:0] d  [3];
      logic signed [33:0] one;
      logic signed [33:0] ng;
      one = $signed({2'b00, ONE_Q30});
      for (int n = 0; n < 9; n++) begin
         rx[n] = r2_ff[n];
      end
      if (tpos_ff) begin
         arg_in = trace_ff + one;
         d[0]   = rx[7] - rx[5];
         d[1]   = rx[2] - rx[6];
         d[2]   = rx[3] - rx[1];
      end else begin
         case (axis_ff)
            AXIS_X: begin
               arg_in = rx[0] - rx[4] - rx[8] + one;
               d[0]   = rx[7] - rx[5];
               d[1]   = rx[3] + rx[1];
               d[2]   = rx[6] + rx[2];
            end
            AXIS_Y: begin
               arg_in = rx[4] - rx[8] - rx[0] + one;
               d[0]   = rx[2] - rx[6];
               d[1]   = rx[7] + rx[5];
               d[2]   = rx[1] + rx[3];
            end
            AXIS_Z: begin
               arg_in = rx[8] - rx[0] - rx[4] + one;
               d[0]   = rx[3] - rx[1];
               d[1]   = rx[2] + rx[6];
               d[2]   = rx[5] + rx[7];
            end
            default: begin
               arg_in = one;
               d[0]   = '0;
               d[1]   = '0;
               d[2]   = '0;
            end
         endcase
      end
      for (int s = 0; s < 3; s++) begin
         dneg_in[s] = d[s][33];
         ng         = 34'sd0 - d[s];
         dmag_in[s] = d[s][33] ? ng[31:0] : d[s][31:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < 9; n++) begin
         r1_ff[n] <= r1_in[n];
         r2_ff[n] <= r1_ff[n];
      end
      sb1_ff   <= side_b_ff[DIV_LAT-1];
      sb2_ff   <= sb1_ff;
      sb3_ff   <= sb2_ff;
      trace_ff <= trace_in;
      axis_ff  <= axis_in;
      tpos_ff  <= (trace_in > 34'sd0);
      arg_ff   <= arg_in;
      dneg_ff  <= dneg_in;
      dmag_ff  <= dmag_in;
      axis3_ff <= axis_ff;
      tpos3_ff <= tpos_ff;
      bad3_ff  <= sb2_ff.bad | (~tpos_ff & (arg_in <= 34'sd0)) | r_unused & 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= vb_ff[DIV_LAT-1];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // ---------------- quaternion root ----------------
   side_c_type          side_c_in;
   side_c_type          side_c_ff [SQ_LAT];
   logic [SQ_LAT-1:0]   vc_ff;
   logic [31:0]         qroot;

   always_comb begin
      side_c_in.move      = sb3_ff.move;
      side_c_in.len       = sb3_ff.len;
      side_c_in.bad       = bad3_ff;
      side_c_in.trace_pos = tpos3_ff;
      side_c_in.axis      = axis3_ff;
      side_c_in.dneg      = dneg_ff;
      side_c_in.dmag      = dmag_ff;
   end

   amdtrs_sqrt u_qroot (
      .clock    (clock),
      .radicand ({arg_ff[33:0], 30'd0}),
      .root     (qroot)
   );

   always_ff @(posedge clock) begin
      side_c_ff[0] <= side_c_in;
      for (int n = 1; n < SQ_LAT; n++) begin
         side_c_ff[n] <= side_c_ff[n-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= '0;
      end else begin
         vc_ff <= {vc_ff[SQ_LAT-2:0], v3_ff};
      end
   end

   // ---------------- off-diagonal terms ----------------
   side_c_type          sc_end;
   side_d_type          side_d_in;
   side_d_type          side_d_ff [DIV_LAT];
   logic [DIV_LAT-1:0]  vd_ff;
   logic [QB-1:0]       cq    [3];
   logic                cqneg [3];
   logic                covf  [3];

   assign sc_end = side_c_ff[SQ_LAT-1];

   always_comb begin
      side_d_in.move      = sc_end.move;
      side_d_in.len       = sc_end.len;
      side_d_in.bad       = sc_end.bad;
      side_d_in.trace_pos = sc_end.trace_pos;
      side_d_in.axis      = sc_end.axis;
      side_d_in.root      = qroot;
   end

   for (genvar s = 0; s < 3; s++) begin : g_term
      amdtrs_div u_div (
         .clock   (clock),
         .neg_in  (sc_end.dneg[s]),
         .mag     ({1'b0, sc_end.dmag[s], 29'd0}),
         .den     (qroot),
         .quot    (cq[s]),
         .neg_out (cqneg[s]),
         .ovf     (covf[s])
      );
   end

   always_ff @(posedge clock) begin
      side_d_ff[0] <= side_d_in;
      for (int n = 1; n < DIV_LAT; n++) begin
         side_d_ff[n] <= side_d_ff[n-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= '0;
      end else begin
         vd_ff <= {vd_ff[DIV_LAT-2:0], vc_ff[SQ_LAT-1]};
      end
   end

   // ---------------- assemble and output ----------------
   side_d_type          sd_end;
   logic signed [31:0]  qw_in, qx_in, qy_in, qz_in;
   logic signed [31:0]  qw_ff, qx_ff, qy_ff, qz_ff;
   side_d_type          out_ff;
   logic                rv_ff;

   assign sd_end = side_d_ff[DIV_LAT-1];

   always_comb begin
      logic signed [31:0] val [3];
      logic        [31:0] mg;
      logic signed [31:0] diag;
      for (int s = 0; s < 3; s++) begin
         if (covf[s] || ({1'b0, cq[s]} > ONE_Q30)) begin
            mg = ONE_Q30;
         end else begin
            mg = {1'b0, cq[s]};
         end
         val[s] = cqneg[s] ? $signed(32'd0 - mg) : $signed(mg);
      end
      diag = $signed({1'b0, sd_end.root[31:1]});
      if (sd_end.bad) begin
         qw_in = $signed(ONE_Q30);
         qx_in = '0;
         qy_in = '0;
         qz_in = '0;
      end else if (sd_end.trace_pos) begin
         qw_in = diag;
         qx_in = val[0];
         qy_in = val[1];
         qz_in = val[2];
      end else begin
         qw_in = val[0];
         case (sd_end.axis)
            AXIS_X: begin
               qx_in = diag;
               qy_in = val[1];
               qz_in = val[2];
            end
            AXIS_Y: begin
               qy_in = diag;
               qz_in = val[1];
               qx_in = val[2];
            end
            AXIS_Z: begin
               qz_in = diag;
               qx_in = val[1];
               qy_in = val[2];
            end
            default: begin
               qx_in = '0;
               qy_in = '0;
               qz_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      qw_ff  <= qw_in;
      qx_ff  <= qx_in;
      qy_ff  <= qy_in;
      qz_ff  <= qz_in;
      out_ff <= sd_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= vd_ff[DIV_LAT-1];
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_move_x     = $signed(out_ff.move[0]);
   assign rsp_move_y     = $signed(out_ff.move[1]);
   assign rsp_move_z     = $signed(out_ff.move[2]);
   assign rsp_quat_w     = qw_ff;
   assign rsp_quat_x     = qx_ff;
   assign rsp_quat_y     = qy_ff;
   assign rsp_quat_z     = qz_ff;
   assign rsp_size_x     = out_ff.len[0];
   assign rsp_size_y     = out_ff.len[1];
   assign rsp_size_z     = out_ff.len[2];
   assign rsp_bad_matrix = out_ff.bad;
endmodule

FILE: hdl/amdtrs_sqrt.sv
// Pipelined 64-bit integer square root, one root bit per stage.
module amdtrs_sqrt
   import amdtrs_pkg::*;
(
   input  logic        clock,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   logic [35:0] rem_ff  [SQ_STEPS];
   logic [31:0] rt_ff   [SQ_STEPS];
   logic [63:0] val_ff  [SQ_STEPS];
   logic [35:0] rem_in  [SQ_STEPS];
   logic [31:0] rt_in   [SQ_STEPS];
   logic [63:0] val_in  [SQ_STEPS];

   always_comb begin
      logic [35:0] rp;
      logic [31:0] qp;
      logic [63:0] vp;
      logic [35:0] rn;
      logic [35:0] tr;
      for (int s = 0; s < SQ_STEPS; s++) begin
         if (s == 0) begin
            rp = '0;
            qp = '0;
            vp = radicand;
         end else begin
            rp = rem_ff[s-1];
            qp = rt_ff[s-1];
            vp = val_ff[s-1];
         end
         rn = {rp[33:0], vp[63:62]};
         tr = {2'b00, qp, 2'b01};
         if (rn >= tr) begin
            rem_in[s] = rn - tr;
            rt_in[s]  = {qp[30:0], 1'b1};
         end else begin
            rem_in[s] = rn;
            rt_in[s]  = {qp[30:0], 1'b0};
         end
         val_in[s] = {vp[61:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < SQ_STEPS; s++) begin
         rem_ff[s] <= rem_in[s];
         rt_ff[s]  <= rt_in[s];
         val_ff[s] <= val_in[s];
      end
   end

   assign root = rt_ff[SQ_STEPS-1];
endmodule

FILE: hdl/amdtrs_div.sv
// Pipelined unsigned restoring divider, 31 quotient bits with overflow flag.
module amdtrs_div
   import amdtrs_pkg::*;
(
   input  logic          clock,
   input  logic          neg_in,
   input  logic [61:0]   mag,
   input  logic [31:0]   den,
   output logic [QB-1:0] quot,
   output logic          neg_out,
   output logic          ovf
);
   logic [32:0]   rem_ff  [DIV_LAT];
   logic [QB-1:0] low_ff  [DIV_LAT];
   logic [QB-1:0] q_ff    [DIV_LAT];
   logic [31:0]   den_ff  [DIV_LAT];
   logic          neg_ff  [DIV_LAT];
   logic          ovf_ff  [DIV_LAT];
   logic [32:0]   rem_in  [DIV_LAT];
   logic [QB-1:0] q_in    [DIV_LAT];

   // setup stage: high part of the dividend is the first partial remainder
   always_comb begin
      logic [32:0] rn;
      rem_in[0] = {2'b00, mag[61:QB]};
      q_in[0]   = '0;
      for (int s = 1; s < DIV_LAT; s++) begin
         rn = {rem_ff[s-1][31:0], low_ff[s-1][QB-1]};
         if (rn >= {1'b0, den_ff[s-1]}) begin
            rem_in[s] = rn - {1'b0, den_ff[s-1]};
            q_in[s]   = {q_ff[s-1][QB-2:0], 1'b1};
         end else begin
            rem_in[s] = rn;
            q_in[s]   = {q_ff[s-1][QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in[0];
      q_ff[0]   <= q_in[0];
      low_ff[0] <= mag[QB-1:0];
      den_ff[0] <= den;
      neg_ff[0] <= neg_in;
      ovf_ff[0] <= ({2'b00, mag[61:QB]} >= {1'b0, den});
      for (int s = 1; s < DIV_LAT; s++) begin
         rem_ff[s] <= rem_in[s];
         q_ff[s]   <= q_in[s];
         low_ff[s] <= {low_ff[s-1][QB-2:0], 1'b0};
         den_ff[s] <= den_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
         ovf_ff[s] <= ovf_ff[s-1];
      end
   end

   assign quot    = q_ff[DIV_LAT-1];
   assign neg_out = neg_ff[DIV_LAT-1];
   assign ovf     = ovf_ff[DIV_LAT-1];
endmodule

FILE: hdl/amdtrs_chk.sv
// Port-level checker for the decomposition block, bound to the top level.
`include "affine_matrix_decompose_trs_top_defines.svh"
module amdtrs_chk
   import amdtrs_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_quat_w,
   input logic signed [31:0] rsp_quat_x,
   input logic signed [31:0] rsp_quat_y,
   input logic signed [31:0] rsp_quat_z,
   input logic        [31:0] rsp_size_x,
   input logic        [31:0] rsp_size_y,
   input logic        [31:0] rsp_size_z,
   input logic               rsp_bad_matrix
);
   logic signed [31:0] qmax, qmin;
   logic               quat_ident;
   logic               quat_range;
   logic               size_zero;
   logic               bad_rsp;

   assign qmax       = $signed(ONE_Q30);
   assign qmin       = -$signed(ONE_Q30);
   assign quat_ident = (rsp_quat_w == qmax) && (rsp_quat_x == '0) &&
                       (rsp_quat_y == '0) && (rsp_quat_z == '0);
   assign quat_range = (rsp_quat_w <= qmax) && (rsp_quat_w >= qmin) &&
                       (rsp_quat_x <= qmax) && (rsp_quat_x >= qmin) &&
                       (rsp_quat_y <= qmax) && (rsp_quat_y >= qmin) &&
                       (rsp_quat_z <= qmax) && (rsp_quat_z >= qmin);
   assign size_zero  = (rsp_size_x == '0) || (rsp_size_y == '0) || (rsp_size_z == '0);
   assign bad_rsp    = rsp_valid && rsp_bad_matrix;

   `AMD_ASSERT_ALWAYS(a_no_busy, clock, reset, !busy, "busy raised")
   `AMD_ASSERT_IMPLY(a_bad_identity, clock, reset, bad_rsp, quat_ident, "bad without identity")
   `AMD_ASSERT_IMPLY(a_zero_size_bad, clock, reset, rsp_valid && size_zero, rsp_bad_matrix, "zero size")
   `AMD_ASSERT_IMPLY(a_quat_range, clock, reset, rsp_valid, quat_range, "quaternion out of range")
endmodule

bind affine_matrix_decompose_trs_top amdtrs_chk u_amdtrs_chk (.*);
